>>> hw/rtl/sem_pkg.sv
// Shared types and constants of the Sobel edge magnitude core.
`default_nettype none
package sem_pkg;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int LINE_AW      = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int TAIL_W       = 11;
    localparam int PIX_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int GRAY_MUL     = 683;
    localparam int GRAY_SHIFT   = 11;

    localparam logic [CFG_IDX_W-1:0]    CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]    CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET      = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET     = 13'd480;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef struct packed {
        t_op              operation;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             last_of_frame;
    } t_out;

    typedef struct packed {
        logic [CFG_WIDTH_W-1:0]  width;
        logic [CFG_HEIGHT_W-1:0] height;
    } t_geom;

    // one queued job for the back end
    typedef struct packed {
        logic             shift;
        logic             emit;
        logic             interior;
        logic             last;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_entry;
endpackage
`default_nettype wire

>>> hw/rtl/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/sem_fifo.sv
// Short job queue between front and back end.
`default_nettype none
module sem_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sem_pkg::t_entry i_push_data,
    input  wire logic            i_pop,
    output sem_pkg::t_entry      o_head,
    output logic                 o_full,
    output logic                 o_empty
);
    sem_pkg::t_entry                r_slot [sem_pkg::QUEUE_DEPTH];
    logic [sem_pkg::QUEUE_AW-1:0]   r_wptr, r_rptr;
    logic [sem_pkg::QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == (sem_pkg::QUEUE_AW+1)'(sem_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/sem_front.sv
// Front end: accepts items, converts to gray, runs line stores and frame counters.
`default_nettype none
module sem_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sem_pkg::t_geom  i_geom,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire sem_pkg::t_in    i_in_data,
    output logic                 o_push,
    output sem_pkg::t_entry      o_push_data,
    input  wire logic            i_full
);
    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_READ = 2'b10
    } t_fstate;

    localparam int SUM_W  = sem_pkg::PIX_W + 2;
    localparam int PROD_W = SUM_W + 10;

    t_fstate                          r_state;
    logic [sem_pkg::LINE_AW-1:0]      r_col, r_wcol;
    logic [sem_pkg::ROW_W-1:0]        r_row;
    logic [sem_pkg::TAIL_W-1:0]       r_tail;
    logic [sem_pkg::PIX_W-1:0]        r_gray;
    logic                             r_emit, r_int;

    logic                             accept, is_pix, is_drain, col_end, row_end;
    logic [SUM_W-1:0]                 sum;
    logic [PROD_W-1:0]                prod;
    logic [sem_pkg::PIX_W-1:0]        gray;
    logic [sem_pkg::TAIL_W-1:0]       tail_init;
    logic                             wr;
    logic [2*sem_pkg::PIX_W-1:0]      rdata;

    assign o_in_ready = (r_state == F_IDLE) && !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_pix     = accept && (i_in_data.operation == sem_pkg::OP_PIXEL) && (r_tail == '0);
    assign is_drain   = accept && (i_in_data.operation == sem_pkg::OP_DRAIN) && (r_tail != '0);

    // divide by three through a reciprocal, exact for sums below 2048
    assign sum  = SUM_W'(i_in_data.red) + SUM_W'(i_in_data.green) + SUM_W'(i_in_data.blue);
    assign prod = PROD_W'(sum) * PROD_W'(sem_pkg::GRAY_MUL);
    assign gray = prod[sem_pkg::GRAY_SHIFT +: sem_pkg::PIX_W];

    assign col_end   = ({1'b0, r_col} + 1'b1) >= i_geom.width;
    assign row_end   = (sem_pkg::CFG_HEIGHT_W'(r_row) + 1'b1) >= i_geom.height;
    assign tail_init = (i_geom.height == sem_pkg::CFG_HEIGHT_W'(1)) ?
                       i_geom.width : i_geom.width + 1'b1;

    assign wr = (r_state == F_READ) && !i_full;

    sem_ram #(
        .WIDTH (2*sem_pkg::PIX_W),
        .DEPTH (sem_pkg::MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (r_wcol),
        .i_wdata ({rdata[sem_pkg::PIX_W-1:0], r_gray}),
        .i_re    (is_pix),
        .i_raddr (r_col),
        .o_rdata (rdata)
    );

    always_comb begin
        o_push      = is_drain || wr;
        o_push_data = '0;
        if (wr) begin
            o_push_data.shift    = 1'b1;
            o_push_data.emit     = r_emit;
            o_push_data.interior = r_int;
            o_push_data.top      = rdata[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
            o_push_data.mid      = rdata[sem_pkg::PIX_W-1:0];
            o_push_data.bot      = r_gray;
        end else begin
            o_push_data.emit = 1'b1;
            o_push_data.last = (r_tail == sem_pkg::TAIL_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_pix) begin
            r_wcol <= r_col;
            r_gray <= gray;
            r_emit <= (r_row >= sem_pkg::ROW_W'(2)) ||
                      ((r_row == sem_pkg::ROW_W'(1)) && (r_col != '0));
            r_int  <= (r_row >= sem_pkg::ROW_W'(2)) && (r_col >= sem_pkg::LINE_AW'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_tail  <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (is_drain) begin
                        r_tail <= r_tail - 1'b1;
                    end
                    if (is_pix) begin
                        r_state <= F_READ;
                        if (col_end) begin
                            r_col <= '0;
                            if (row_end) begin
                                r_row  <= '0;
                                r_tail <= tail_init;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                F_READ: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/sem_back.sv
// Back end: 3x3 window, Sobel gradients, iterative root and output register.
`default_nettype none
module sem_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sem_pkg::t_entry i_head,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output sem_pkg::t_out        o_out_data
);
    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_GRAD = 5'b00010,
        B_SQ   = 5'b00100,
        B_ROOT = 5'b01000,
        B_OUT  = 5'b10000
    } t_bstate;

    localparam int G_W   = sem_pkg::PIX_W + 3;
    localparam int A_W   = sem_pkg::PIX_W + 2;
    localparam int S_W   = 2*A_W + 1;
    localparam int BIT_W = $clog2(sem_pkg::PIX_W);

    t_bstate                          r_state;
    logic [2:0][2:0][sem_pkg::PIX_W-1:0] r_win;
    logic [A_W-1:0]                   r_ax, r_ay;
    logic [S_W-1:0]                   r_sum;
    logic [sem_pkg::PIX_W-1:0]        r_root, r_res;
    logic [BIT_W-1:0]                 r_bit;
    logic                             r_last;

    logic signed [G_W-1:0]            gx, gy;
    logic [sem_pkg::PIX_W-1:0]        trial;
    logic [2*sem_pkg::PIX_W-1:0]      trial_sq;
    logic                             out_load;

    function automatic logic signed [G_W-1:0] wt(input logic [sem_pkg::PIX_W-1:0] a,
                                                 input logic [sem_pkg::PIX_W-1:0] b,
                                                 input logic [sem_pkg::PIX_W-1:0] c);
        wt = $signed(G_W'(a)) + $signed(G_W'({b, 1'b0})) + $signed(G_W'(c));
    endfunction

    assign gx = wt(r_win[0][2], r_win[1][2], r_win[2][2])
              - wt(r_win[0][0], r_win[1][0], r_win[2][0]);
    assign gy = wt(r_win[2][0], r_win[2][1], r_win[2][2])
              - wt(r_win[0][0], r_win[0][1], r_win[0][2]);

    assign trial    = r_root | (sem_pkg::PIX_W'(1) << r_bit);
    assign trial_sq = (2*sem_pkg::PIX_W)'(trial) * (2*sem_pkg::PIX_W)'(trial);

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign out_load = (r_state == B_OUT) && (!o_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (o_pop && i_head.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_head.top;
            r_win[1][2] <= i_head.mid;
            r_win[2][2] <= i_head.bot;
        end
        if (o_pop) begin
            r_last <= i_head.last;
            r_res  <= '0;
        end
        if (r_state == B_GRAD) begin
            r_ax <= A_W'(gx[G_W-1] ? -gx : gx);
            r_ay <= A_W'(gy[G_W-1] ? -gy : gy);
        end
        if (r_state == B_SQ) begin
            r_sum  <= S_W'(r_ax) * S_W'(r_ax) + S_W'(r_ay) * S_W'(r_ay);
            r_root <= '0;
            r_bit  <= BIT_W'(sem_pkg::PIX_W - 1);
        end
        if (r_state == B_ROOT) begin
            if (S_W'(trial_sq) <= r_sum) begin
                r_root <= trial;
            end
            r_bit <= r_bit - 1'b1;
            // magnitude of 256 or more saturates
            if (r_bit == '0) begin
                if (r_sum >= S_W'(1 << (2*sem_pkg::PIX_W))) begin
                    r_res <= '0;
                end else if (S_W'(trial_sq) <= r_sum) begin
                    r_res <= ~trial;
                end else begin
                    r_res <= ~r_root;
                end
            end
        end
        if (out_load) begin
            o_out_data.edge_value    <= r_res;
            o_out_data.last_of_frame <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop && i_head.emit) begin
                        r_state <= i_head.interior ? B_GRAD : B_OUT;
                    end
                end
                B_GRAD: r_state <= B_SQ;
                B_SQ:   r_state <= B_ROOT;
                B_ROOT: begin
                    if (r_bit == '0) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/sobel_edge_magnitude_core.sv
// Top level of the streaming Sobel edge magnitude core.
`default_nettype none
// Takes RGB pixels in raster order and returns 255 minus the clamped Sobel
// gradient magnitude of each pixel, 0 on the frame border, trailing the input
// by frame_width+1 positions; drain items flush the tail of a frame and pixels
// sent while a tail is owed are dropped. The front end reads then writes back
// the line store per pixel before taking more, and takes a drain item every
// cycle unless the queue is full. The back end runs interior results through
// gradient, squares and an eight-step bit-serial root, border and tail results
// straight to output, popping no job until done; a four-entry queue between
// them absorbs bursts. Uncleared line stores hold garbage until written.
module sobel_edge_magnitude_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire sem_pkg::t_in                    i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output sem_pkg::t_out                        o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sem_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sem_pkg::CFG_HEIGHT_W-1:0] i_cfg_data
);
    logic [sem_pkg::CFG_WIDTH_W-1:0]  r_frame_width;
    logic [sem_pkg::CFG_HEIGHT_W-1:0] r_frame_height;
    sem_pkg::t_geom                   geom;
    logic                             push, pop, full, empty;
    sem_pkg::t_entry                  push_data, head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sem_pkg::WIDTH_RESET;
            r_frame_height <= sem_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == sem_pkg::CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data[sem_pkg::CFG_WIDTH_W-1:0];
            end else if (i_cfg_index == sem_pkg::CFG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data;
            end
        end
    end

    // clamp the frame size to what the line stores and counters hold
    always_comb begin
        geom.width = r_frame_width;
        if (r_frame_width == '0) begin
            geom.width = sem_pkg::CFG_WIDTH_W'(1);
        end else if (r_frame_width > sem_pkg::CFG_WIDTH_W'(sem_pkg::MAX_WIDTH)) begin
            geom.width = sem_pkg::CFG_WIDTH_W'(sem_pkg::MAX_WIDTH);
        end
        geom.height = r_frame_height;
        if (r_frame_height == '0) begin
            geom.height = sem_pkg::CFG_HEIGHT_W'(1);
        end else if (r_frame_height > sem_pkg::CFG_HEIGHT_W'(sem_pkg::MAX_HEIGHT)) begin
            geom.height = sem_pkg::CFG_HEIGHT_W'(sem_pkg::MAX_HEIGHT);
        end
    end

    sem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    sem_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_full      (full),
        .o_empty     (empty)
    );

    sem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire
